[design/sta_pkg.sv]
`timescale 1ns / 1ps
// Package for the sinusoid tone adder: beat types, register indexes, wave codes
// and the quarter-wave sine table generator. It depends on nothing else.
package sta_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_OUT_BITS   = 16;
  localparam int TAB_LEN         = 1 << SINE_TABLE_BITS;
  localparam int DATA_W          = 32;
  localparam int CFG_IDX_W       = 3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1 << 30;

  // Each Taylor term is divided by (2k)(2k+1); these reciprocals make that exact
  // for every term value the series can produce.
  localparam longint unsigned RECIP_1  = 64'(((128'd1 << 64) / 128'd6) + 128'd1);
  localparam longint unsigned RECIP_2  = 64'(((128'd1 << 64) / 128'd20) + 128'd1);
  localparam longint unsigned RECIP_3  = 64'(((128'd1 << 64) / 128'd42) + 128'd1);
  localparam longint unsigned RECIP_4  = 64'(((128'd1 << 64) / 128'd72) + 128'd1);
  localparam longint unsigned RECIP_5  = 64'(((128'd1 << 64) / 128'd110) + 128'd1);
  localparam longint unsigned RECIP_6  = 64'(((128'd1 << 64) / 128'd156) + 128'd1);
  localparam longint unsigned RECIP_7  = 64'(((128'd1 << 64) / 128'd210) + 128'd1);
  localparam longint unsigned RECIP_8  = 64'(((128'd1 << 64) / 128'd272) + 128'd1);
  localparam longint unsigned RECIP_9  = 64'(((128'd1 << 64) / 128'd342) + 128'd1);
  localparam longint unsigned RECIP_10 = 64'(((128'd1 << 64) / 128'd420) + 128'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_KIND      = 3'd0,
    REG_TONE_FREQUENCY = 3'd1,
    REG_TONE_PHASE     = 3'd2,
    REG_TONE_AMPLITUDE = 3'd3,
    REG_TONE_OFFSET    = 3'd4,
    REG_WRITE_REAL     = 3'd5,
    REG_WRITE_IMAG     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WAVE_NONE   = 2'd0,
    WAVE_SINE   = 2'd1,
    WAVE_COSINE = 2'd2
  } wave_kind_t;

  typedef struct packed {
    logic        [DATA_W-1:0] sample_time;
    logic signed [DATA_W-1:0] real_acc_in;
    logic signed [DATA_W-1:0] imag_acc_in;
    logic                     last_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] real_acc_out;
    logic signed [DATA_W-1:0] imag_acc_out;
    logic                     last_out;
  } out_beat_t;

  function automatic longint unsigned taylor_recip(input int unsigned k);
    longint unsigned r;
    case (k)
      1: r = RECIP_1;
      2: r = RECIP_2;
      3: r = RECIP_3;
      4: r = RECIP_4;
      5: r = RECIP_5;
      6: r = RECIP_6;
      7: r = RECIP_7;
      8: r = RECIP_8;
      9: r = RECIP_9;
      10: r = RECIP_10;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // Entry idx of the quarter-wave table, built by an integer Taylor series in Q30.
  function automatic logic [SINE_OUT_BITS-2:0] sine_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned scale;
    longint unsigned rnd;
    logic [127:0]    wide;
    longint          sum;
    int unsigned     k;
    scale = (64'd1 << (SINE_OUT_BITS - 1)) - 64'd1;
    x     = (HALF_PI_Q30 * (longint'(idx) * 2 + 1)) >> (SINE_TABLE_BITS + 1);
    x2    = (x * x) >> 30;
    term  = x;
    sum   = longint'(x);
    for (k = 1; k <= 10; k++) begin
      wide = 128'((term * x2) >> 30) * 128'(taylor_recip(k));
      term = wide[127:64];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    rnd = (longint'(sum) * scale + (64'd1 << 29)) >> 30;
    return rnd[SINE_OUT_BITS-2:0];
  endfunction

endpackage

[design/sinusoid_tone_adder.sv]
`timescale 1ns / 1ps
// Sinusoid tone adder top level: a seven-stage pipeline with its register file.
// It depends on sta_pkg for types, codes and the sine table.
//
// Usage: input beats arrive on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data, and the tone registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data, which is always ready.
// Each input beat yields exactly one output beat, in order.
// An accepted beat passes through the seven registered stages before out_valid
// rises, and a new beat can be accepted every cycle unless in_stall is high. The
// stages are the phase multiply, the phase add, the table read, the
// amplitude multiply, the rounding, the offset add and the saturating
// accumulate, which is also the output register.
// Reset clears every stage valid bit and loads the register defaults: no tone,
// real accumulator selected. When the receiver stalls, the output beat holds
// and empty stages behind it keep filling; in_stall rises only once all
// seven stages hold a beat.
// Registers should be written only while the pipeline is empty.
module sinusoid_tone_adder
  import sta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int PW = DATA_W + SINE_OUT_BITS;
  localparam int TW = DATA_W + 1;
  localparam int AW = DATA_W + 2;
  localparam int SW = DATA_W + 3;
  localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) << (SINE_OUT_BITS - 2);
  localparam logic [DATA_W-1:0] QUARTER_CYCLE = DATA_W'(1) << (DATA_W - 2);

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
  } carry_t;

  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SW-1:0] s);
    logic signed [DATA_W-1:0] r;
    if (s[SW-1:DATA_W-1] == '0 || s[SW-1:DATA_W-1] == '1) begin
      r = s[DATA_W-1:0];
    end else if (s[SW-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic [SINE_OUT_BITS-2:0] sine_rom [TAB_LEN];

  for (genvar g = 0; g < TAB_LEN; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  logic [1:0]               wave_kind_r;
  logic [DATA_W-1:0]        tone_freq_r;
  logic [DATA_W-1:0]        tone_phase_r;
  logic signed [DATA_W-1:0] tone_amp_r;
  logic signed [DATA_W-1:0] tone_offset_r;
  logic                     write_real_r;
  logic                     write_imag_r;
  logic                     tone_on;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  carry_t d1_r, d2_r, d3_r, d4_r, d5_r, d6_r;
  carry_t d1_nxt;

  logic [DATA_W-1:0]           ph1_r, ph1_nxt;
  logic [DATA_W-1:0]           cyc2;
  logic                        neg2_r, neg2_nxt;
  logic [SINE_TABLE_BITS-1:0]  pos2_r, pos2_nxt;
  logic [SINE_OUT_BITS-2:0]    rom3_r;
  logic signed [DATA_W:0]      amp3_r, amp3_nxt;
  logic signed [PW-1:0]        prod4_r, prod4_nxt;
  logic signed [PW-1:0]        biased5;
  logic signed [TW-1:0]        tone5_r, tone5_nxt;
  logic signed [AW-1:0]        add6_r, add6_nxt;
  logic signed [SW-1:0]        re_sum7, im_sum7;
  out_beat_t                   out_beat_r, out_beat_nxt;

  assign cfg_ready = 1'b1;
  assign tone_on = (wave_kind_r == WAVE_SINE) || (wave_kind_r == WAVE_COSINE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_kind_r   <= WAVE_NONE;
      tone_freq_r   <= '0;
      tone_phase_r  <= '0;
      tone_amp_r    <= '0;
      tone_offset_r <= '0;
      write_real_r  <= 1'b1;
      write_imag_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WAVE_KIND:      wave_kind_r   <= cfg_data[1:0];
        REG_TONE_FREQUENCY: tone_freq_r   <= cfg_data;
        REG_TONE_PHASE:     tone_phase_r  <= cfg_data;
        REG_TONE_AMPLITUDE: tone_amp_r    <= cfg_data;
        REG_TONE_OFFSET:    tone_offset_r <= cfg_data;
        REG_WRITE_REAL:     write_real_r  <= cfg_data[0];
        REG_WRITE_IMAG:     write_imag_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en7 = !v7_r || !out_stall;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  always_comb begin
    d1_nxt.re   = in_data.real_acc_in;
    d1_nxt.im   = in_data.imag_acc_in;
    d1_nxt.last = in_data.last_in;
    ph1_nxt     = tone_freq_r * in_data.sample_time;

    cyc2 = ph1_r + tone_phase_r;
    if (wave_kind_r == WAVE_COSINE) begin
      cyc2 = cyc2 + QUARTER_CYCLE;
    end
    neg2_nxt = cyc2[DATA_W-1];
    pos2_nxt = cyc2[DATA_W-3 -: SINE_TABLE_BITS];
    if (cyc2[DATA_W-2]) begin
      pos2_nxt = ~pos2_nxt;
    end

    amp3_nxt = {tone_amp_r[DATA_W-1], tone_amp_r};
    if (neg2_r) begin
      amp3_nxt = -amp3_nxt;
    end

    prod4_nxt = amp3_r * $signed({1'b0, rom3_r});

    biased5   = prod4_r + ROUND_BIAS;
    tone5_nxt = biased5[PW-1:SINE_OUT_BITS-1];

    add6_nxt = {{2{tone_offset_r[DATA_W-1]}}, tone_offset_r} + {tone5_r[TW-1], tone5_r};

    re_sum7 = {{3{d6_r.re[DATA_W-1]}}, d6_r.re} + {add6_r[AW-1], add6_r};
    im_sum7 = {{3{d6_r.im[DATA_W-1]}}, d6_r.im} + {add6_r[AW-1], add6_r};
    out_beat_nxt.real_acc_out = (tone_on && write_real_r) ? sat_sum(re_sum7) : d6_r.re;
    out_beat_nxt.imag_acc_out = (tone_on && write_imag_r) ? sat_sum(im_sum7) : d6_r.im;
    out_beat_nxt.last_out     = d6_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
      if (en6) begin
        v6_r <= v5_r;
      end
      if (en7) begin
        v7_r <= v6_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r  <= d1_nxt;
      ph1_r <= ph1_nxt;
    end
    if (en2) begin
      d2_r   <= d1_r;
      neg2_r <= neg2_nxt;
      pos2_r <= pos2_nxt;
    end
    if (en3) begin
      d3_r   <= d2_r;
      rom3_r <= sine_rom[pos2_r];
      amp3_r <= amp3_nxt;
    end
    if (en4) begin
      d4_r    <= d3_r;
      prod4_r <= prod4_nxt;
    end
    if (en5) begin
      d5_r    <= d4_r;
      tone5_r <= tone5_nxt;
    end
    if (en6) begin
      d6_r   <= d5_r;
      add6_r <= add6_nxt;
    end
    if (en7) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = v7_r;
  assign out_data  = out_beat_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted input beat did not enter the first stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && v6_r && v7_r && out_stall))
    else $error("input stalled while the pipeline had room");

  a_real_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && en7 && !(tone_on && write_real_r)) |=>
      (out_data.real_acc_out == $past(d6_r.re)))
    else $error("real sum changed although no tone is added to it");

endmodule

[bench/sinusoid_tone_adder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sinusoid tone adder, with its own tone predictor and sine table.
// It depends on sta_pkg and the sinusoid_tone_adder top level.
module sinusoid_tone_adder_tb;
  import sta_pkg::*;

  localparam int PIPE_LATENCY = 7;
  localparam int SETTING_ITEMS = 40;
  localparam logic [1:0] WAVE_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  logic [1:0] tone_kind;
  logic [31:0] tone_freq;
  logic [31:0] tone_phase;
  logic signed [31:0] tone_amp;
  logic signed [31:0] tone_offset;
  logic tone_wr_real;
  logic tone_wr_imag;

  longint sine_table[TAB_LEN];
  out_beat_t pending_sums[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int settings_written = 0;

  sinusoid_tone_adder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : fill_sine_table
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned scale;
    longint sum;
    int i;
    int k;
    scale = (64'd1 << (SINE_OUT_BITS - 1)) - 64'd1;
    for (i = 0; i < TAB_LEN; i++) begin
      x = (HALF_PI_Q30 * (64'd2 * i + 64'd1)) / (64'd2 * TAB_LEN);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (k = 1; k <= 10; k++) begin
        term = ((term * x2) >> 30) / ((64'd2 * k) * (64'd2 * k + 64'd1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      sine_table[i] = longint'(($unsigned(sum) * scale + (64'd1 << 29)) >> 30);
    end
  end

  function automatic longint clamp_to_word(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_beat_t predict_sum(input in_beat_t beat);
    out_beat_t res;
    longint unsigned prod;
    logic [31:0] p;
    logic [1:0] quad;
    logic [SINE_TABLE_BITS-1:0] pos;
    longint w;
    longint m;
    longint tone;
    longint add;
    longint re;
    longint im;
    re = longint'($signed(beat.real_acc_in));
    im = longint'($signed(beat.imag_acc_in));
    if (tone_kind == WAVE_SINE || tone_kind == WAVE_COSINE) begin
      prod = {32'd0, tone_freq} * {32'd0, beat.sample_time};
      p = prod[31:0] + tone_phase;
      if (tone_kind == WAVE_COSINE) begin
        p = p + 32'h4000_0000;
      end
      quad = p[31:30];
      pos = p[29 -: SINE_TABLE_BITS];
      if (quad[0]) begin
        pos = ~pos;
      end
      w = quad[1] ? -sine_table[pos] : sine_table[pos];
      m = longint'(tone_amp) * w;
      tone = (m + (longint'(1) << (SINE_OUT_BITS - 2))) >>> (SINE_OUT_BITS - 1);
      add = longint'(tone_offset) + tone;
      if (tone_wr_real) begin
        re = clamp_to_word(re + add);
      end
      if (tone_wr_imag) begin
        im = clamp_to_word(im + add);
      end
    end
    res.real_acc_out = re[31:0];
    res.imag_acc_out = im[31:0];
    res.last_out = beat.last_in;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("Mismatch on %s of result %0d: expected %h, got %h.", field, results_checked,
             want, got);
    mismatch_count++;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, out_data.real_acc_out);
      end else begin
        want = pending_sums.pop_front();
        if (out_data.real_acc_out !== want.real_acc_out) begin
          report_mismatch("real sum", want.real_acc_out, out_data.real_acc_out);
        end
        if (out_data.imag_acc_out !== want.imag_acc_out) begin
          report_mismatch("imaginary sum", want.imag_acc_out, out_data.imag_acc_out);
        end
        if (out_data.last_out !== want.last_out) begin
          report_mismatch("last marker", {31'd0, want.last_out}, {31'd0, out_data.last_out});
        end
      end
      results_checked++;
    end
  end

  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (pending_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [31:0] t, input logic [31:0] re,
                             input logic [31:0] im, input logic last);
    in_beat_t beat;
    beat.sample_time = t;
    beat.real_acc_in = re;
    beat.imag_acc_in = im;
    beat.last_in = last;
    in_valid = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
    end
    in_data = beat;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_sums.push_back(predict_sum(beat));
    samples_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_tone_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] value);
    drain_pipeline();
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WAVE_KIND: tone_kind = value[1:0];
      REG_TONE_FREQUENCY: tone_freq = value;
      REG_TONE_PHASE: tone_phase = value;
      REG_TONE_AMPLITUDE: tone_amp = value;
      REG_TONE_OFFSET: tone_offset = value;
      REG_WRITE_REAL: tone_wr_real = value[0];
      REG_WRITE_IMAG: tone_wr_imag = value[0];
      default: ;
    endcase
    settings_written++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Narrow registers get random upper bits, which the block must ignore.
  task automatic write_tone(input logic [1:0] kind, input logic [31:0] freq,
                            input logic [31:0] phase, input logic [31:0] amp,
                            input logic [31:0] offset, input logic wr_re, input logic wr_im);
    write_tone_register(REG_WAVE_KIND, ($urandom() & ~32'h3) | {30'd0, kind});
    write_tone_register(REG_TONE_FREQUENCY, freq);
    write_tone_register(REG_TONE_PHASE, phase);
    write_tone_register(REG_TONE_AMPLITUDE, amp);
    write_tone_register(REG_TONE_OFFSET, offset);
    write_tone_register(REG_WRITE_REAL, ($urandom() & ~32'h1) | {31'd0, wr_re});
    write_tone_register(REG_WRITE_IMAG, ($urandom() & ~32'h1) | {31'd0, wr_im});
  endtask

  task automatic test_pass_through_after_reset();
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
  endtask

  task automatic test_sine_and_cosine_quadrants();
    write_tone(WAVE_SINE, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'd0, 1'b1, 1'b1);
    send_sample(32'h0000_0000, 32'd0, 32'd0, 1'b0);
    send_sample(32'h0000_3FFF, 32'd0, 32'd0, 1'b0);
    send_sample(32'h0000_4000, 32'd0, 32'd0, 1'b0);
    send_sample(32'h0000_8000, 32'd0, 32'd0, 1'b0);
    send_sample(32'h0000_C000, 32'd0, 32'd0, 1'b1);
    write_tone(WAVE_COSINE, 32'h0001_0000, 32'h2000_0000, 32'hFFFF_0000, 32'h0000_8000,
               1'b1, 1'b0);
    send_sample(32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    send_sample(32'h0000_4000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    send_sample(32'h0000_8000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    send_sample(32'h0000_C000, 32'h0001_0000, 32'h0002_0000, 1'b1);
  endtask

  task automatic test_unused_kind_and_index();
    write_tone(WAVE_RESERVED, 32'h0003_0000, 32'h1234_5678, 32'h0004_0000, 32'h0001_0000,
               1'b1, 1'b1);
    send_sample(32'h0000_1000, 32'h0000_0100, 32'hFFFF_FF00, 1'b0);
    write_tone_register(REG_RESERVED, 32'hFFFF_FFFF);
    write_tone_register(REG_WAVE_KIND, {30'd0, WAVE_SINE});
    send_sample(32'h0000_1000, 32'h0000_0100, 32'hFFFF_FF00, 1'b1);
  endtask

  task automatic test_saturation_and_flags();
    write_tone(WAVE_SINE, 32'd0, 32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    write_tone(WAVE_SINE, 32'd0, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    send_sample(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    write_tone(WAVE_COSINE, 32'h0001_0000, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
  endtask

  task automatic test_extreme_phase_inputs();
    write_tone(WAVE_SINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               1'b1, 1'b1);
    send_sample(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 32'h7FFF_FFFF, 32'd0, 1'b1);
  endtask

  task automatic test_random_tones(input int sender_pct, input int receiver_pct,
                                   input int settings);
    logic [1:0] kind;
    logic [31:0] freq;
    logic [31:0] phase;
    logic [31:0] amp;
    logic [31:0] offset;
    logic [31:0] t;
    logic [31:0] re;
    logic [31:0] im;
    int s;
    int n;
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    for (s = 0; s < settings; s++) begin
      case ($urandom_range(9))
        0: kind = WAVE_NONE;
        1: kind = WAVE_RESERVED;
        2, 3, 4, 5: kind = WAVE_SINE;
        default: kind = WAVE_COSINE;
      endcase
      case ($urandom_range(3))
        0: freq = $urandom();
        1: freq = $urandom_range(32'h00FF_FFFF);
        2: freq = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        default: freq = $urandom_range(32'h0010_0000);
      endcase
      phase = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0) : $urandom();
      case ($urandom_range(3))
        0: amp = $urandom();
        1: amp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: amp = $urandom_range(32'h0008_0000) - 32'h0004_0000;
      endcase
      case ($urandom_range(4))
        0: offset = $urandom();
        1: offset = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: offset = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      endcase
      write_tone(kind, freq, phase, amp, offset, 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      for (n = 0; n < SETTING_ITEMS; n++) begin
        t = $urandom_range(1) ? $urandom() : $urandom_range(32'h000F_FFFF);
        case ($urandom_range(3))
          0: re = $urandom();
          1: re = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: re = $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
        endcase
        case ($urandom_range(3))
          0: im = $urandom();
          1: im = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: im = $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
        endcase
        send_sample(t, re, im, $urandom_range(7) == 0);
        // Hold the sender until the pipeline has emptied once mid-setting.
        if (s == 0 && n == SETTING_ITEMS / 2) begin
          drain_pipeline();
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tone_kind = WAVE_NONE;
    tone_freq = '0;
    tone_phase = '0;
    tone_amp = '0;
    tone_offset = '0;
    tone_wr_real = 1'b1;
    tone_wr_imag = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 20;
    recv_stall_pct = 20;
    test_pass_through_after_reset();
    test_sine_and_cosine_quadrants();
    test_unused_kind_and_index();
    test_saturation_and_flags();
    test_extreme_phase_inputs();
    test_random_tones(37, 83, 5);
    test_random_tones(83, 37, 5);
    test_random_tones(0, 0, 5);

    recv_stall_pct = 0;
    drain_pipeline();
    $display("Ran %0d samples and %0d register writes; %0d results compared.", samples_sent,
             settings_written, results_checked);
    $display("Covered sine, cosine, pass-through, saturation and three idle patterns.");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected.", pending_sums.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
